### hdl/rcmq_pkg.sv
// Shared constants and control types for the range raise / range maximum tree.
`timescale 1ns / 1ps
`default_nettype none
package rcmq_pkg;

  localparam int DATA_W            = 32;
  localparam int POS_W             = 10;
  localparam int CFG_W             = 11;
  localparam int POSITIONS_DEFAULT = 1024;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // func codes
  localparam logic FUNC_RAISE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clr;       // write zero at addr (clearing pass)
    logic load;      // capture a new word, zero the accumulator
    logic rd;        // read the node at addr
    logic wr;        // combine the node read last cycle, write it back on a raise
    logic path;      // node lies on a leaf-to-root path (else a cover node)
    logic out_load;  // move the accumulator into the result register
  } rcmq_cmd_t;

endpackage
`default_nettype wire

### hdl/rcmq_if.sv
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps
`default_nettype none
interface rcmq_in_if;
  import rcmq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [POS_W-1:0]        range_low;
  logic [POS_W-1:0]        range_high;
  logic [DATA_W-1:0]       update_value;

  modport source (output valid, func, range_low, range_high, update_value, input ready);
  modport sink   (input valid, func, range_low, range_high, update_value, output ready);
endinterface

interface rcmq_out_if;
  import rcmq_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] range_maximum;

  modport source (output valid, range_maximum, input ready);
  modport sink   (input valid, range_maximum, output ready);
endinterface
`default_nettype wire

### hdl/range_chmax_max_query_tree_top.sv
// Top level of the range raise-to-at-least / range maximum tree.
//
//  channel  | dir | handshake           | payload
//  in_if    | in  | valid / ready       | func, range_low, range_high, update_value
//  out_if   | out | valid / ready       | range_maximum
//  cfg_     | in  | cfg_we, no wait     | cfg_wdata = positions_in_use
//
// A word walks the tree level by level, from leaves to root: per level
// up to two cover nodes and two path nodes, each a read and then a write
// on the single node memory. After reset a clearing pass writes all
// 2*leaves entries before the first word is taken. A held result stalls
// only the end of the next query.
`timescale 1ns / 1ps
`default_nettype none
module range_chmax_max_query_tree_top #(
  parameter int POSITIONS = rcmq_pkg::POSITIONS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  rcmq_in_if.sink                         in_if,
  rcmq_out_if.source                      out_if,
  input  wire logic                       cfg_we,
  input  wire logic [rcmq_pkg::CFG_W-1:0] cfg_wdata
);
  import rcmq_pkg::*;

  localparam int ADDR_W = $clog2(POSITIONS) + 1;

  rcmq_cmd_t         cmd;
  logic [ADDR_W-1:0] addr;

  rcmq_ctrl #(.POSITIONS(POSITIONS), .ADDR_W(ADDR_W)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_func   (in_if.func),
    .in_low    (in_if.range_low),
    .in_high   (in_if.range_high),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .addr      (addr)
  );

  rcmq_dp #(.POSITIONS(POSITIONS), .ADDR_W(ADDR_W)) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .addr     (addr),
    .in_func  (in_if.func),
    .in_value (in_if.update_value),
    .out_data (out_if.range_maximum)
  );

endmodule
`default_nettype wire

### hdl/rcmq_ctrl.sv
// Controller: clearing pass, tree walk sequencing and result handshake.
`timescale 1ns / 1ps
`default_nettype none
module rcmq_ctrl #(
  parameter int POSITIONS = rcmq_pkg::POSITIONS_DEFAULT,
  parameter int ADDR_W    = $clog2(POSITIONS) + 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_func,
  input  wire logic [rcmq_pkg::POS_W-1:0] in_low,
  input  wire logic [rcmq_pkg::POS_W-1:0] in_high,
  input  wire logic                       cfg_we,
  input  wire logic [rcmq_pkg::CFG_W-1:0] cfg_wdata,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output rcmq_pkg::rcmq_cmd_t             cmd,
  output logic [ADDR_W-1:0]               addr
);
  import rcmq_pkg::*;

  localparam int LEAVES = 1 << (ADDR_W - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_RD    = 6'b001000,
    S_WR    = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  piu_r;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ADDR_W:0]   l_r, l_nxt, r_r, r_nxt;
  logic [ADDR_W-1:0] a_r, a_nxt, b_r, b_nxt, node_r, node_nxt;
  logic [1:0]        sub_r, sub_nxt;
  logic              path_r, path_nxt;
  logic              query_r, query_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [31:0]       n_w, hi_w, lo_w;
  logic              empty;
  logic              cand_vld;
  logic [ADDR_W-1:0] cand_node;
  logic              cand_path;
  logic              accept;

  // clamp the used span and the range end
  always_comb begin
    n_w = {{(32-CFG_W){1'b0}}, piu_r};
    if (n_w == 32'd0) n_w = 32'd1;
    if (n_w > 32'(POSITIONS)) n_w = 32'(POSITIONS);
    lo_w = {{(32-POS_W){1'b0}}, in_low};
    hi_w = {{(32-POS_W){1'b0}}, in_high};
    if (hi_w > n_w - 32'd1) hi_w = n_w - 32'd1;
    empty = lo_w > hi_w;
  end

  // node to visit at this step of the current level
  always_comb begin
    cand_vld  = 1'b0;
    cand_node = a_r;
    cand_path = 1'b1;
    case (sub_r)
      2'd0: begin
        cand_vld  = (l_r < r_r) && l_r[0];
        cand_node = l_r[ADDR_W-1:0];
        cand_path = 1'b0;
      end
      2'd1: begin
        cand_vld  = (l_r < r_r) && r_r[0];
        cand_node = ADDR_W'(r_r - (ADDR_W+1)'(1));
        cand_path = 1'b0;
      end
      2'd2: begin
        cand_vld  = 1'b1;
        cand_node = a_r;
      end
      default: begin
        cand_vld  = a_r != b_r;
        cand_node = b_r;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    node_nxt      = node_r;
    sub_nxt       = sub_r;
    path_nxt      = path_r;
    query_nxt     = query_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = state_r == S_IDLE;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        clr_nxt = clr_r + ADDR_W'(1);
        if (&clr_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          query_nxt = in_func == FUNC_QUERY;
          l_nxt     = (ADDR_W+1)'(lo_w + 32'(LEAVES));
          r_nxt     = (ADDR_W+1)'(hi_w + 32'(LEAVES) + 32'd1);
          a_nxt     = ADDR_W'(lo_w + 32'(LEAVES));
          b_nxt     = ADDR_W'(hi_w + 32'(LEAVES));
          sub_nxt   = 2'd0;
          if (empty) begin
            if (in_func == FUNC_QUERY) state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cand_vld) begin
          node_nxt  = cand_node;
          path_nxt  = cand_path;
          state_nxt = S_RD;
        end else if (sub_r != 2'd3) begin
          sub_nxt = sub_r + 2'd1;
        end else if (a_r == ADDR_W'(1)) begin
          state_nxt = S_DONE;
        end else begin
          l_nxt   = (l_r + (ADDR_W+1)'(l_r[0])) >> 1;
          r_nxt   = (r_r - (ADDR_W+1)'(r_r[0])) >> 1;
          a_nxt   = a_r >> 1;
          b_nxt   = b_r >> 1;
          sub_nxt = 2'd0;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        cmd.path  = path_r;
        state_nxt = S_SCAN;
        if (sub_r != 2'd3) begin
          sub_nxt = sub_r + 2'd1;
        end else if (a_r == ADDR_W'(1)) begin
          state_nxt = S_DONE;
        end else begin
          l_nxt   = (l_r + (ADDR_W+1)'(l_r[0])) >> 1;
          r_nxt   = (r_r - (ADDR_W+1)'(r_r[0])) >> 1;
          a_nxt   = a_r >> 1;
          b_nxt   = b_r >> 1;
          sub_nxt = 2'd0;
        end
      end
      S_DONE: begin
        if (!query_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign addr      = (state_r == S_CLEAR) ? clr_r : node_r;
  assign out_valid = out_valid_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      piu_r       <= CFG_RESET;
      sub_r       <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
      if (cfg_we) piu_r <= cfg_wdata;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    l_r     <= l_nxt;
    r_r     <= r_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    node_r  <= node_nxt;
    path_r  <= path_nxt;
    query_r <= query_nxt;
  end

endmodule
`default_nettype wire

### hdl/rcmq_dp.sv
// Datapath: node memory {raise tag, span maximum}, combine logic, result register.
`timescale 1ns / 1ps
`default_nettype none
module rcmq_dp #(
  parameter int POSITIONS = rcmq_pkg::POSITIONS_DEFAULT,
  parameter int ADDR_W    = $clog2(POSITIONS) + 1
) (
  input  wire logic                        clk,
  input  wire rcmq_pkg::rcmq_cmd_t         cmd,
  input  wire logic [ADDR_W-1:0]           addr,
  input  wire logic                        in_func,
  input  wire logic [rcmq_pkg::DATA_W-1:0] in_value,
  output logic      [rcmq_pkg::DATA_W-1:0] out_data
);
  import rcmq_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  // each entry: upper half tag of raises covering the whole span, lower half span max
  logic [2*DATA_W-1:0] mem [DEPTH];
  logic [2*DATA_W-1:0] rdata_r;
  logic [2*DATA_W-1:0] wdata;
  logic [DATA_W-1:0]   v_r, acc_r, out_r;
  logic                raise_r;
  logic [DATA_W-1:0]   tag, mx, new_tag, new_mx, pick;

  assign tag     = rdata_r[2*DATA_W-1:DATA_W];
  assign mx      = rdata_r[DATA_W-1:0];
  assign new_mx  = (mx > v_r) ? mx : v_r;
  assign new_tag = (cmd.path || tag > v_r) ? tag : v_r;
  assign wdata   = {new_tag, new_mx};
  assign pick    = cmd.path ? tag : mx;

  // node memory
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[addr] <= '0;
    end else if (cmd.wr && raise_r) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) rdata_r <= mem[addr];
  end

  // word registers and query accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r     <= in_value;
      raise_r <= in_func == FUNC_RAISE;
      acc_r   <= '0;
    end else if (cmd.wr && !raise_r && pick > acc_r) begin
      acc_r <= pick;
    end
    if (cmd.out_load) out_r <= acc_r;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire
